// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the polynomial kernel block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PKE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PKE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/pke_pkg.sv -----
// ----------------------------------------------------------------------------
// pke_pkg
// Widths, fixed-point constants, register indexes and shared types.
// ----------------------------------------------------------------------------
package pke_pkg;

   localparam int ELEMENT_BITS_DEF = 16;
   localparam int FRAC_BITS        = 24;
   localparam int Q_BITS           = 48;
   localparam int ACC_BITS         = 64;
   localparam int HALF_BITS        = Q_BITS / 2;
   localparam int PROD_BITS        = 2 * Q_BITS;
   localparam int DEG_BITS         = 4;
   localparam int CSR_INDEX_BITS   = 1;
   localparam int CSR_DATA_BITS    = DEG_BITS;
   localparam int STEP_BITS        = 3;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QPTR_BITS        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS        = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [Q_BITS-1:0] Q_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
   localparam logic signed [Q_BITS-1:0] Q_MIN = {1'b1, {(Q_BITS-1){1'b0}}};
   localparam logic signed [Q_BITS-1:0] ONE_Q = Q_BITS'(64'd1 << FRAC_BITS);
   localparam logic [Q_BITS-1:0] Q_MAX_MAG = {1'b0, {(Q_BITS-1){1'b1}}};
   localparam logic [Q_BITS-1:0] Q_MIN_MAG = {1'b1, {(Q_BITS-1){1'b0}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   localparam logic [DEG_BITS-1:0] DEGREE_RESET  = 4'd2;
   localparam logic                ADD_ONE_RESET = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_POLY_DEGREE = 1'b0,
      REG_ADD_ONE     = 1'b1
   } pke_reg_index_type;

   // Shift codes for partial products of the split multiplier.
   localparam logic [1:0] SHIFT_NONE = 2'd0;
   localparam logic [1:0] SHIFT_HALF = 2'd1;
   localparam logic [1:0] SHIFT_FULL = 2'd2;

   // One finished dot product waiting for its power step.
   typedef struct packed {
      logic signed [Q_BITS-1:0] value;
      logic                     clip;
      logic [DEG_BITS-1:0]      degree;
   } pke_entry_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOAD,
      BK_MUL,
      BK_ROUND,
      BK_SAT,
      BK_EMIT
   } pke_back_state_type;

endpackage

// ----- design/pke_queue.sv -----
// ----------------------------------------------------------------------------
// pke_queue
// Small FIFO of dot-product entries between the front and the power unit.
// ----------------------------------------------------------------------------
module pke_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pke_pkg::pke_entry_type  push_entry,
   input  logic                    pop,
   output pke_pkg::pke_entry_type  head_entry,
   output logic [pke_pkg::QCNT_BITS-1:0] count
);
   import pke_pkg::*;

   pke_entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

// ----- design/pke_front.sv -----
// ----------------------------------------------------------------------------
// pke_front
// Multiply element pairs, accumulate with saturation, clamp and queue.
// ----------------------------------------------------------------------------
module pke_front #(
   parameter int ELEMENT_BITS = pke_pkg::ELEMENT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic signed [ELEMENT_BITS-1:0]  a_element,
   input  logic signed [ELEMENT_BITS-1:0]  b_element,
   input  logic                            last_pair,
   input  logic [pke_pkg::DEG_BITS-1:0]    poly_degree,
   input  logic                            add_one,
   output logic                            push,
   output pke_pkg::pke_entry_type          push_entry,
   output logic [1:0]                      pend_lasts
);
   import pke_pkg::*;

   localparam int PROD_W = 2 * ELEMENT_BITS;

   // stage 1: product
   logic                     s1_valid_ff;
   logic                     s1_last_ff;
   logic signed [PROD_W-1:0] s1_prod_ff, s1_prod_in;

   // stage 2: accumulator and finished sum
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;
   logic                       clip_ff, clip_in;
   logic                       s2_valid_ff, s2_valid_in;
   logic signed [ACC_BITS-1:0] s2_acc_ff, s2_acc_in;
   logic                       s2_clip_ff, s2_clip_in;

   logic signed [ACC_BITS-1:0] prod_ext;
   logic signed [ACC_BITS:0]   sum_w;
   logic                       ovf;
   logic signed [ACC_BITS-1:0] acc_sat;
   logic signed [ACC_BITS:0]   val_w;

   assign s1_prod_in = a_element * b_element;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_prod_ff <= s1_prod_in;
         s1_last_ff <= last_pair;
      end
   end

   assign prod_ext = ACC_BITS'(s1_prod_ff);
   assign sum_w    = (ACC_BITS+1)'(acc_ff) + (ACC_BITS+1)'(prod_ext);
   assign ovf      = sum_w[ACC_BITS] != sum_w[ACC_BITS-1];
   assign acc_sat  = ovf ? (sum_w[ACC_BITS] ? ACC_MIN : ACC_MAX) : sum_w[ACC_BITS-1:0];

   always_comb begin
      acc_in      = acc_ff;
      clip_in     = clip_ff;
      s2_valid_in = 1'b0;
      s2_acc_in   = s2_acc_ff;
      s2_clip_in  = s2_clip_ff;
      if (s1_valid_ff) begin
         if (s1_last_ff) begin
            // hand the finished sum on and start the next vector from zero
            acc_in      = '0;
            clip_in     = 1'b0;
            s2_valid_in = 1'b1;
            s2_acc_in   = acc_sat;
            s2_clip_in  = clip_ff | ovf;
         end else begin
            acc_in  = acc_sat;
            clip_in = clip_ff | ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         clip_ff     <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         acc_ff      <= acc_in;
         clip_ff     <= clip_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_acc_ff  <= s2_acc_in;
      s2_clip_ff <= s2_clip_in;
   end

   // stage 3: add the constant, clamp to Q24.24, push
   assign val_w = (ACC_BITS+1)'(s2_acc_ff) + (add_one ? (ACC_BITS+1)'(ONE_Q) : '0);

   always_comb begin
      push_entry.degree = poly_degree;
      push_entry.clip   = s2_clip_ff;
      push_entry.value  = val_w[Q_BITS-1:0];
      priority if (s2_acc_ff > ACC_BITS'(Q_MAX)) begin
         push_entry.value = Q_MAX;
         push_entry.clip  = 1'b1;
      end else if (val_w > (ACC_BITS+1)'(Q_MAX)) begin
         push_entry.value = Q_MAX;
         push_entry.clip  = 1'b1;
      end else if (val_w < (ACC_BITS+1)'(Q_MIN)) begin
         push_entry.value = Q_MIN;
         push_entry.clip  = 1'b1;
      end else begin
         push_entry.value = val_w[Q_BITS-1:0];
      end
   end

   assign push       = s2_valid_ff;
   assign pend_lasts = {1'b0, s1_valid_ff & s1_last_ff} + {1'b0, s2_valid_ff};

endmodule

// ----- design/pke_back.sv -----
// ----------------------------------------------------------------------------
// pke_back
// Power sequencer: repeated Q24.24 multiply with floor rounding and clamp.
// ----------------------------------------------------------------------------
module pke_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [pke_pkg::QCNT_BITS-1:0]  q_count,
   input  pke_pkg::pke_entry_type         head_entry,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [pke_pkg::Q_BITS-1:0] kernel_value,
   output logic                           saturated
);
   import pke_pkg::*;

   pke_back_state_type state_ff, state_in;

   logic signed [Q_BITS-1:0]   x_val_ff, x_val_in;
   logic [Q_BITS-1:0]          x_mag_ff, x_mag_in;
   logic                       x_neg_ff, x_neg_in;
   logic [Q_BITS-1:0]          r_mag_ff, r_mag_in;
   logic                       r_neg_ff, r_neg_in;
   logic signed [Q_BITS-1:0]   res_ff, res_in;
   logic                       clip_ff, clip_in;
   logic [DEG_BITS-1:0]        deg_ff, deg_in;
   logic [DEG_BITS-1:0]        iter_ff, iter_in;
   logic [STEP_BITS-1:0]       step_ff, step_in;
   logic [Q_BITS-1:0]          pp_ff, pp_in;
   logic [1:0]                 shift_ff, shift_in;
   logic [PROD_BITS-1:0]       prod_ff, prod_in;
   logic [Q_BITS:0]            q_ff, q_in;
   logic                       big_ff, big_in;
   logic                       neg_ff, neg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [Q_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   logic [HALF_BITS-1:0]       a_half, b_half;
   logic [PROD_BITS-1:0]       pp_shifted;
   logic [DEG_BITS-1:0]        iter_next;

   assign a_half    = step_ff[1] ? r_mag_ff[Q_BITS-1:HALF_BITS] : r_mag_ff[HALF_BITS-1:0];
   assign b_half    = step_ff[0] ? x_mag_ff[Q_BITS-1:HALF_BITS] : x_mag_ff[HALF_BITS-1:0];
   assign iter_next = iter_ff + 1'b1;

   always_comb begin
      unique case (shift_ff)
         SHIFT_NONE: pp_shifted = PROD_BITS'(pp_ff);
         SHIFT_HALF: pp_shifted = PROD_BITS'(pp_ff) << HALF_BITS;
         SHIFT_FULL: pp_shifted = PROD_BITS'(pp_ff) << Q_BITS;
         default:    pp_shifted = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      x_val_in     = x_val_ff;
      x_mag_in     = x_mag_ff;
      x_neg_in     = x_neg_ff;
      r_mag_in     = r_mag_ff;
      r_neg_in     = r_neg_ff;
      res_in       = res_ff;
      clip_in      = clip_ff;
      deg_in       = deg_ff;
      iter_in      = iter_ff;
      step_in      = step_ff;
      pp_in        = pp_ff;
      shift_in     = shift_ff;
      prod_in      = prod_ff;
      q_in         = q_ff;
      big_in       = big_ff;
      neg_in       = neg_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop          = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_count != '0) begin
               pop      = 1'b1;
               x_val_in = head_entry.value;
               clip_in  = head_entry.clip;
               deg_in   = head_entry.degree;
               res_in   = ONE_Q;
               r_mag_in = ONE_Q;
               r_neg_in = 1'b0;
               iter_in  = '0;
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            x_neg_in = x_val_ff[Q_BITS-1];
            x_mag_in = x_val_ff[Q_BITS-1] ? -x_val_ff : x_val_ff;
            step_in  = '0;
            state_in = (deg_ff == '0) ? BK_EMIT : BK_MUL;
         end
         BK_MUL: begin
            // multiply one half pair per cycle and add the registered product of the previous step
            if (step_ff < STEP_BITS'(4)) begin
               pp_in    = a_half * b_half;
               shift_in = 2'(step_ff[1]) + 2'(step_ff[0]);
            end
            if (step_ff != '0) begin
               prod_in = ((step_ff == STEP_BITS'(1)) ? '0 : prod_ff) + pp_shifted;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(4)) begin
               state_in = BK_ROUND;
            end
         end
         BK_ROUND: begin
            neg_in   = r_neg_ff ^ x_neg_ff;
            big_in   = |prod_ff[PROD_BITS-1:FRAC_BITS+Q_BITS];
            q_in     = (Q_BITS+1)'(prod_ff[FRAC_BITS+Q_BITS-1:FRAC_BITS])
                     + (Q_BITS+1)'((r_neg_ff ^ x_neg_ff) && (|prod_ff[FRAC_BITS-1:0]));
            state_in = BK_SAT;
         end
         BK_SAT: begin
            priority if (big_ff) begin
               clip_in  = 1'b1;
               res_in   = neg_ff ? Q_MIN : Q_MAX;
               r_mag_in = neg_ff ? Q_MIN_MAG : Q_MAX_MAG;
               r_neg_in = neg_ff;
            end else if (neg_ff) begin
               if (q_ff > (Q_BITS+1)'(Q_MIN_MAG)) begin
                  clip_in  = 1'b1;
                  res_in   = Q_MIN;
                  r_mag_in = Q_MIN_MAG;
                  r_neg_in = 1'b1;
               end else begin
                  res_in   = $signed(-q_ff[Q_BITS-1:0]);
                  r_mag_in = q_ff[Q_BITS-1:0];
                  r_neg_in = q_ff != '0;
               end
            end else begin
               if (q_ff > (Q_BITS+1)'(Q_MAX_MAG)) begin
                  clip_in  = 1'b1;
                  res_in   = Q_MAX;
                  r_mag_in = Q_MAX_MAG;
               end else begin
                  res_in   = $signed(q_ff[Q_BITS-1:0]);
                  r_mag_in = q_ff[Q_BITS-1:0];
               end
               r_neg_in = 1'b0;
            end
            iter_in  = iter_next;
            step_in  = '0;
            state_in = (iter_next == deg_ff) ? BK_EMIT : BK_MUL;
         end
         BK_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_sat_in   = clip_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_val_ff     <= x_val_in;
      x_mag_ff     <= x_mag_in;
      x_neg_ff     <= x_neg_in;
      r_mag_ff     <= r_mag_in;
      r_neg_ff     <= r_neg_in;
      res_ff       <= res_in;
      clip_ff      <= clip_in;
      deg_ff       <= deg_in;
      iter_ff      <= iter_in;
      step_ff      <= step_in;
      pp_ff        <= pp_in;
      shift_ff     <= shift_in;
      prod_ff      <= prod_in;
      q_ff         <= q_in;
      big_ff       <= big_in;
      neg_ff       <= neg_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign kernel_value = rsp_value_ff;
   assign saturated    = rsp_sat_ff;

endmodule

// ----- design/polynomial_kernel_eval_top.sv -----
// ----------------------------------------------------------------------------
// polynomial_kernel_eval_top
// Polynomial kernel (x.y + c)^d over two streamed vectors, Q24.24 result.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    a_element, b_element, last_pair
//   rsp      out        rsp_valid/stall    kernel_value, saturated
//   csr      in         csr_write_en       csr_index, csr_wdata
//
// The front takes one element pair per cycle while req_stall is low. The
// power unit takes one vector at a time and, for degree d, runs d multiplies
// (four 24x24 partial products, their sum, round, clamp per multiply);
// short vectors are paced by the power unit, and the four-entry queue
// soaks up bursts. Reset is synchronous and clears control state and the
// accumulator; registers return to degree 2, add_one set. req_stall rises
// when the queue plus lasts still in the front fill the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polynomial_kernel_eval_top #(
   parameter int ELEMENT_BITS = pke_pkg::ELEMENT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ELEMENT_BITS-1:0]      req_a_element,
   input  logic signed [ELEMENT_BITS-1:0]      req_b_element,
   input  logic                                req_last_pair,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pke_pkg::Q_BITS-1:0]   rsp_kernel_value,
   output logic                                rsp_saturated,
   input  logic                                csr_write_en,
   input  logic [pke_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pke_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import pke_pkg::*;

   // configuration registers
   logic [DEG_BITS-1:0]   poly_degree_ff, poly_degree_in;
   logic                  add_one_ff, add_one_in;

   logic                  req_accept;
   logic                  q_push;
   logic                  q_pop;
   pke_entry_type         q_push_entry;
   pke_entry_type         q_head;
   logic [QCNT_BITS-1:0]  q_count;
   logic [1:0]            front_pend;

   // Take the write; only the low bits of each register survive.
   always_comb begin
      poly_degree_in = poly_degree_ff;
      add_one_in     = add_one_ff;
      if (csr_write_en) begin
         unique case (pke_reg_index_type'(csr_index))
            REG_POLY_DEGREE: poly_degree_in = csr_wdata[DEG_BITS-1:0];
            REG_ADD_ONE:     add_one_in     = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_degree_ff <= DEGREE_RESET;
         add_one_ff     <= ADD_ONE_RESET;
      end else begin
         poly_degree_ff <= poly_degree_in;
         add_one_ff     <= add_one_in;
      end
   end

   // Hold off new pairs while every queue slot is spoken for: either filled
   // or reserved by a last pair still moving through the front stages.
   assign req_stall = ((QCNT_BITS+1)'(q_count) + (QCNT_BITS+1)'(front_pend))
                      >= (QCNT_BITS+1)'(QUEUE_DEPTH);
   assign req_accept = req_valid && !req_stall;

   // Front: multiply, accumulate, clamp, classify last pairs into the queue.
   pke_front #(
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_accept),
      .a_element   (req_a_element),
      .b_element   (req_b_element),
      .last_pair   (req_last_pair),
      .poly_degree (poly_degree_ff),
      .add_one     (add_one_ff),
      .push        (q_push),
      .push_entry  (q_push_entry),
      .pend_lasts  (front_pend)
   );

   // Queue: decouple the streaming front from the power sequencer.
   pke_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head_entry (q_head),
      .count      (q_count)
   );

   // Back: raise each sum to its degree and drive the output register.
   pke_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_count      (q_count),
      .head_entry   (q_head),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .kernel_value (rsp_kernel_value),
      .saturated    (rsp_saturated)
   );

   // A push never lands on a full queue.
   `PKE_ASSERT_NOW(a_push_has_room, clock, reset, q_push, q_count < QCNT_BITS'(QUEUE_DEPTH), "push into full queue")
   // The power unit only pops a filled slot.
   `PKE_ASSERT_NOW(a_pop_not_empty, clock, reset, q_pop, q_count != '0, "pop from empty queue")
   // An accepted last pair is tracked as pending in the front next cycle.
   `PKE_ASSERT_NEXT(a_last_tracked, clock, reset, req_accept && req_last_pair, front_pend != 2'd0, "last pair lost in front")
   // Filled plus reserved slots never exceed the queue depth.
   `PKE_ASSERT_NOW(a_slots_bounded, clock, reset, 1'b1, ((QCNT_BITS+1)'(q_count) + (QCNT_BITS+1)'(front_pend)) <= (QCNT_BITS+1)'(QUEUE_DEPTH), "queue overcommitted")

endmodule
